/* design/ffba_pkg.sv */
// shared types and constants of the first-fit bitmap allocator
`default_nettype none

package ffba_pkg;

  localparam int unsigned STORE_UNITS_DEF = 1024;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned POS_W = 10;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic             cmd;
    logic [LEN_W-1:0] run_length;
    logic [POS_W-1:0] free_start;
  } in_item_t;

  typedef struct packed {
    logic             failed;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] granted_length;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic mark_init;
    logic wr_en;
    logic wr_val;
    logic set_fail;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_free;
    logic alloc_bad;
    logic free_bad;
    logic free_empty;
    logic found;
    logic scan_end;
    logic wr_last;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/ffba_datapath.sv */
// usage map memory, scan counters and result register of the allocator
`default_nettype none

module ffba_datapath #(
  parameter int unsigned STORE_UNITS = ffba_pkg::STORE_UNITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ffba_pkg::in_item_t in_data_i,
  input  wire ffba_pkg::dp_cmd_t  cmd_i,
  output ffba_pkg::dp_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ffba_pkg::out_item_t     out_data_o
);
  import ffba_pkg::*;

  localparam int unsigned AW = $clog2(STORE_UNITS);
  localparam int unsigned CNT_W = $clog2(STORE_UNITS + 1);
  localparam int unsigned IW = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned SW = ((IW > LEN_W) ? IW : LEN_W) + 1;
  localparam logic [SW-1:0] STORE_S = SW'(STORE_UNITS);
  localparam logic [IW-1:0] STORE_I = IW'(STORE_UNITS);
  localparam logic [IW-1:0] LAST_I = IW'(STORE_UNITS - 1);

  logic map_mem [STORE_UNITS];

  logic             op_q;
  logic             fail_q;
  logic [LEN_W-1:0] len_q;
  logic [IW-1:0]    base_q;
  logic [IW-1:0]    addr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic             rd_data_q;
  logic [IW-1:0]    rd_idx_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             issue;
  logic             hit;
  logic [SW-1:0]    end_s;
  logic             res_ok;

  assign issue  = cmd_i.scan && (addr_q < STORE_I);
  assign hit    = rd_vld_q && !rd_data_q && ((SW'(cnt_q) + SW'(1)) == SW'(len_q));
  assign end_s  = SW'(base_q) + SW'(len_q);
  assign res_ok = !fail_q && (op_q == OP_ALLOC);

  always_comb begin
    stat_o.op_free    = (op_q == OP_FREE);
    stat_o.alloc_bad  = (len_q == '0) || (SW'(len_q) > STORE_S);
    stat_o.free_bad   = (end_s > STORE_S);
    stat_o.free_empty = (len_q == '0);
    stat_o.found      = hit;
    stat_o.scan_end   = rd_vld_q && (rd_idx_q == LAST_I) && !hit;
    stat_o.wr_last    = ((SW'(addr_q) + SW'(1)) == end_s);
    stat_o.clr_last   = (addr_q == LAST_I);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // map memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      map_mem[addr_q[AW-1:0]] <= cmd_i.wr_val;
    end
    if (issue) begin
      rd_data_q <= map_mem[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.load) begin
        addr_q <= (in_data_i.cmd == OP_FREE) ? IW'(in_data_i.free_start) : '0;
      end else if (cmd_i.mark_init) begin
        addr_q <= base_q;
      end else if (issue || cmd_i.wr_en) begin
        addr_q <= addr_q + IW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= addr_q;
    end
    if (cmd_i.load) begin
      op_q   <= in_data_i.cmd;
      len_q  <= in_data_i.run_length;
      fail_q <= 1'b0;
      cnt_q  <= '0;
      base_q <= (in_data_i.cmd == OP_FREE) ? IW'(in_data_i.free_start) : '0;
    end else begin
      if (cmd_i.set_fail) begin
        fail_q <= 1'b1;
      end
      if (cmd_i.scan && rd_vld_q) begin
        if (rd_data_q) begin
          cnt_q  <= '0;
          base_q <= rd_idx_q + IW'(1);
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
    if (cmd_i.out_load) begin
      out_q.failed         <= fail_q;
      out_q.position       <= res_ok ? POS_W'(base_q) : '0;
      out_q.granted_length <= res_ok ? len_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* design/ffba_ctrl.sv */
// sequencing state machine of the allocator
`default_nettype none

module ffba_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ffba_pkg::dp_stat_t stat_i,
  output ffba_pkg::dp_cmd_t       cmd_o
);
  import ffba_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DISPATCH = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_WRITE    = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat_i.op_free) begin
          if (stat_i.free_bad) begin
            cmd_o.set_fail = 1'b1;
            state_d        = ST_DONE;
          end else if (stat_i.free_empty) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_WRITE;
          end
        end else if (stat_i.alloc_bad) begin
          cmd_o.set_fail = 1'b1;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.found) begin
          cmd_o.mark_init = 1'b1;
          state_d         = ST_WRITE;
        end else if (stat_i.scan_end) begin
          cmd_o.set_fail = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_val = !stat_i.op_free;
        if (stat_i.wr_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/first_fit_bitmap_allocator_core.sv */
// one transaction at a time; input is stalled until the result is loaded for output
// a refused length or range, or an allocate with no fit, returns a failed result
// allocate scans the map serially for the first fitting run, then marks it; free clears its run
// reset: asynchronous, active low; a clearing pass then zeroes the map
// and input stays stalled until it ends
`default_nettype none

module first_fit_bitmap_allocator_core #(
  parameter int unsigned STORE_UNITS = ffba_pkg::STORE_UNITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ffba_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ffba_pkg::out_item_t      out_data_o
);
  import ffba_pkg::*;

  // command and status bundles between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: clear pass, dispatch, scan, mark/free sweep, result hand-off
  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // map memory, run counter and output register
  ffba_datapath #(
    .STORE_UNITS (STORE_UNITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a failed transaction never reports a position or a length
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.failed |->
      (out_data_o.position == '0) && (out_data_o.granted_length == '0))
    else $error("failed result carries nonzero position or length");

  // a granted run never exceeds the store
  a_grant_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.failed |-> (out_data_o.granted_length <= STORE_UNITS))
    else $error("granted length exceeds store size");

  // scan and map write never overlap
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.scan && dp_cmd.wr_en))
    else $error("scan and map write in the same cycle");

endmodule

`default_nettype wire
